/* hw/rtl/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared constants and types of the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int MAX_CODE_LEN  = 32;

  localparam int SYM_W   = 8;
  localparam int LEN_W   = 6;
  localparam int CODE_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int TBL_AW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  // stored length saturates at the lesser of MAX_CODE_LEN and the code width
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  localparam logic [SYM_W-1:0] END_SYMBOL = 8'd3;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  // one encode item on its way to the packer; code is left aligned
  typedef struct packed {
    logic              is_end;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } pk_item_t;

endpackage

/* hw/rtl/hcbp_code_table.sv */
// ----------------------------------------------------------------------------
// hcbp_code_table
// Symbol code table: one write port, one registered read port. A valid bit
// per entry makes unwritten entries read as length zero after reset.
// ----------------------------------------------------------------------------
module hcbp_code_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [hcbp_pkg::TBL_AW-1:0] wr_addr,
  input  logic [hcbp_pkg::LEN_W-1:0]  wr_len,
  input  logic [hcbp_pkg::CODE_W-1:0] wr_code,
  input  logic                        rd_en,
  input  logic [hcbp_pkg::TBL_AW-1:0] rd_addr,
  output logic [hcbp_pkg::LEN_W-1:0]  rd_len,
  output logic [hcbp_pkg::CODE_W-1:0] rd_code
);
  import hcbp_pkg::*;

  logic [LEN_W-1:0]  len_mem  [ALPHABET_SIZE];
  logic [CODE_W-1:0] code_mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] vld_r;

  logic [LEN_W-1:0]  rd_len_r;
  logic [CODE_W-1:0] rd_code_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      len_mem[wr_addr]  <= wr_len;
      code_mem[wr_addr] <= wr_code;
    end
    if (rd_en) begin
      rd_len_r  <= len_mem[rd_addr];
      rd_code_r <= code_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_len  = rd_vld_r ? rd_len_r : '0;
  assign rd_code = rd_code_r;

endmodule

/* hw/rtl/hcbp_packer.sv */
// ----------------------------------------------------------------------------
// hcbp_packer
// Merges left-aligned codes into the MSB-first packing byte and hands the
// finished bytes of each item to a byte emitter, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module hcbp_packer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  hcbp_pkg::pk_item_t item,
  output logic               item_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run,
  output logic               out_end_of_stream
);
  import hcbp_pkg::*;

  localparam int WIDE_W = BYTE_W + CODE_W;

  // item stage
  logic     s2_v_r, s2_v_nxt;
  pk_item_t s2_r;

  // packing state
  logic [BYTE_W-1:0] pack_r, pack_nxt;
  logic [3:0]        bc_r, bc_nxt;

  // byte emitter
  logic [WIDE_W-1:0] ebuf_r, ebuf_nxt;
  logic [2:0]        ecnt_r, ecnt_nxt;
  logic              eeos_r, eeos_nxt;

  logic [WIDE_W-1:0] wide;
  logic [6:0]        t_sum, t_m1, rem;
  logic [2:0]        nfull, nbytes;
  logic [BYTE_W-1:0] tail_byte;
  logic              out_acc, buf_free, adv;

  assign out_acc  = out_valid && !out_stall;
  assign buf_free = (ecnt_r == 3'd0) || ((ecnt_r == 3'd1) && !out_stall);

  always_comb begin
    wide  = {pack_r, {CODE_W{1'b0}}} | ({s2_r.code, {BYTE_W{1'b0}}} >> bc_r);
    t_sum = 7'(bc_r) + 7'(s2_r.len);
    t_m1  = t_sum - 7'd1;
    nfull = (s2_r.len == '0) ? 3'd0 : t_m1[5:3];
    nbytes = nfull + 3'(s2_r.is_end);
    rem   = t_sum - {1'b0, nfull, 3'b000};
    case (nfull)
      3'd0:    tail_byte = wide[39:32];
      3'd1:    tail_byte = wide[31:24];
      3'd2:    tail_byte = wide[23:16];
      3'd3:    tail_byte = wide[15:8];
      3'd4:    tail_byte = wide[7:0];
      default: tail_byte = '0;
    endcase
  end

  assign adv       = s2_v_r && ((nbytes == 3'd0) || buf_free);
  assign item_take = !s2_v_r || adv;

  always_comb begin
    s2_v_nxt = item_take ? item_valid : s2_v_r;
    pack_nxt = pack_r;
    bc_nxt   = bc_r;
    ebuf_nxt = ebuf_r;
    ecnt_nxt = ecnt_r;
    eeos_nxt = eeos_r;
    if (out_acc) begin
      ebuf_nxt = ebuf_r << BYTE_W;
      ecnt_nxt = ecnt_r - 3'd1;
    end
    if (adv) begin
      if (s2_r.is_end) begin
        pack_nxt = '0;
        bc_nxt   = '0;
      end else if (s2_r.len != '0) begin
        pack_nxt = tail_byte;
        bc_nxt   = rem[3:0];
      end
      if (nbytes != 3'd0) begin
        ebuf_nxt = wide;
        ecnt_nxt = nbytes;
        eeos_nxt = s2_r.is_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      pack_r <= '0;
      bc_r   <= '0;
      ecnt_r <= '0;
      eeos_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
      pack_r <= pack_nxt;
      bc_r   <= bc_nxt;
      ecnt_r <= ecnt_nxt;
      eeos_r <= eeos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s2_r <= item;
    end
    ebuf_r <= ebuf_nxt;
  end

  assign out_valid         = (ecnt_r != 3'd0);
  assign out_byte          = ebuf_r[WIDE_W-1 -: BYTE_W];
  assign out_last_of_run   = (ecnt_r == 3'd1);
  assign out_end_of_stream = (ecnt_r == 3'd1) && eeos_r;

endmodule

/* hw/rtl/huffman_code_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Huffman encoder back end: code table plus MSB-first bit packer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): command 0 loads symbol's code (length, bits) into
//   the code table; command 1 encodes a symbol. Loads produce no word.
//   Symbol 3 appends its code, then flushes the packing byte zero padded
//   with end_of_stream set, and packing restarts at bit 7.
//   Output channel (out_*): one word per packed byte, first code bit in
//   bit 7. last_of_run marks the final word caused by an input word.
//   Path: an item is read from the table at the accepting edge, then moves
//   through the packer stage into the emit register, which drives out_*.
//   Throughput: one input word per cycle while items yield at most one byte
//   and out_stall is low; an item of N bytes, up to 5, holds the emitter
//   until all N are out. The single table read port and emitter set the rate.
//   Reset: table valid bits, packing byte and bit count all clear at once.
//   out_stall holds the current word; input keeps flowing until the
//   packer stage and table read stage are both full, then in_stall rises.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_symbol,
  input  logic [5:0]  in_code_length,
  input  logic [31:0] in_code_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_end_of_stream
);
  import hcbp_pkg::*;

  logic in_acc, in_alpha;
  logic wr_en, rd_en;
  logic [LEN_W-1:0] wr_len, rd_len;
  logic [CODE_W-1:0] rd_code;
  logic [2*CODE_W-1:0] align_wide;

  // table read stage
  logic s1_v_r, s1_v_nxt;
  logic s1_end_r;

  pk_item_t item;
  logic     item_take;

  // symbols beyond the alphabet are never written to the table
  assign in_alpha = ({1'b0, in_symbol} < 9'(ALPHABET_SIZE));
  assign in_stall = s1_v_r && !item_take;
  assign in_acc   = in_valid && !in_stall;

  assign wr_en  = in_acc && (in_command == CMD_LOAD) && in_alpha;
  assign wr_len = (in_code_length > 6'(LEN_CAP)) ? 6'(LEN_CAP) : in_code_length;
  assign rd_en  = in_acc && (in_command == CMD_ENCODE);

  hcbp_code_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (in_symbol[TBL_AW-1:0]),
    .wr_len  (wr_len),
    .wr_code (in_code_bits),
    .rd_en   (rd_en),
    .rd_addr (in_symbol[TBL_AW-1:0]),
    .rd_len  (rd_len),
    .rd_code (rd_code)
  );

  always_comb begin
    if (rd_en) begin
      s1_v_nxt = 1'b1;
    end else if (item_take) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // out-of-alphabet encodes keep the read going but contribute no bits
  logic s1_alpha_r;
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_end_r   <= (in_symbol == END_SYMBOL);
      s1_alpha_r <= in_alpha;
    end
  end

  // left-align the code: its low len bits land at the top, the rest drop
  assign align_wide = {rd_code, {CODE_W{1'b0}}} >> rd_len;

  always_comb begin
    item.is_end = s1_end_r;
    item.len    = s1_alpha_r ? rd_len : '0;
    item.code   = s1_alpha_r ? align_wide[CODE_W-1:0] : '0;
  end

  hcbp_packer u_packer (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (s1_v_r),
    .item              (item),
    .item_take         (item_take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

endmodule

/* hw/rtl/hcbp_checker.sv */
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks on the packer's output channel.
// ----------------------------------------------------------------------------
module hcbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_of_run,
  input logic       out_end_of_stream
);

  // the flush byte always closes its run
  a_eos_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_end_of_stream || out_last_of_run))
    else $error("end_of_stream word without last_of_run");

  // stalled word holds
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_byte) && $stable(out_last_of_run)
       && $stable(out_end_of_stream)))
    else $error("stalled output word changed");

  // nothing pending right after reset
  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // a word that is not the last of its run is followed by another word
  a_run_cont : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_of_run) |=> out_valid)
    else $error("run ended without last_of_run");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (.*);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Huffman code bit packer. Loads and encodes are
// driven through the input channel in bursts. A scoreboard class models the
// code table and the MSB-first packing byte, and checks every output word in
// order against what it has worked out.
// ----------------------------------------------------------------------------
module tb_top;
  import hcbp_pkg::*;

  // one expected output word
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              eos;
  } packed_byte_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the code table and packer state
  // --------------------------------------------------------------------------
  class packer_scoreboard;
    logic [LEN_W-1:0]  len_tbl[ALPHABET_SIZE];
    logic [CODE_W-1:0] code_tbl[ALPHABET_SIZE];
    logic [BYTE_W-1:0] acc;
    int unsigned       fill;
    packed_byte_t      bytes_due[$];
    int                errors;
    int                words_in;
    int                bytes_out;
    int                flushes;

    function new();
      foreach (len_tbl[i]) begin
        len_tbl[i]  = '0;
        code_tbl[i] = '0;
      end
      acc       = '0;
      fill      = 0;
      errors    = 0;
      words_in  = 0;
      bytes_out = 0;
      flushes   = 0;
    endfunction

    function void push_byte(logic [BYTE_W-1:0] d, logic eos);
      packed_byte_t pb;
      pb.data = d;
      pb.last = 1'b0;
      pb.eos  = eos;
      bytes_due = {bytes_due, pb};
    endfunction

    // accepted input word: update table or pack bits, queue the bytes due
    function void note_word(logic cmd, logic [SYM_W-1:0] sym, logic [LEN_W-1:0] len,
                            logic [CODE_W-1:0] bits);
      int unsigned n_bits;
      int unsigned pos;
      logic [CODE_W-1:0] code;
      int base;
      base = bytes_due.size();
      words_in++;
      if (cmd == CMD_LOAD) begin
        if (int'(sym) < ALPHABET_SIZE) begin
          len_tbl[sym]  = (int'(len) > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
          code_tbl[sym] = bits;
        end
        return;
      end
      if (int'(sym) < ALPHABET_SIZE) begin
        n_bits = len_tbl[sym];
        code   = code_tbl[sym];
        for (int i = 0; i < int'(n_bits); i++) begin
          pos = n_bits - 1 - i;
          // a full byte only leaves once the next bit turns up
          if (fill > 7) begin
            push_byte(acc, 1'b0);
            acc  = '0;
            fill = 0;
          end
          if (code[pos])
            acc = acc | (8'h80 >> fill);
          fill++;
        end
      end
      if (sym == END_SYMBOL) begin
        push_byte(acc, 1'b1);
        acc  = '0;
        fill = 0;
      end
      if (bytes_due.size() > base)
        bytes_due[bytes_due.size()-1].last = 1'b1;
    endfunction

    // accepted output word: compare with the oldest byte due
    function void check_byte(logic [BYTE_W-1:0] d, logic last, logic eos);
      packed_byte_t pb;
      if (bytes_due.size() == 0) begin
        $error("out_byte: word with nothing due, actual %02h last %0b eos %0b",
               d, last, eos);
        errors++;
        return;
      end
      pb = bytes_due.pop_front();
      bytes_out++;
      if (eos === 1'b1)
        flushes++;
      if (d !== pb.data) begin
        $error("out_byte: expected %02h actual %02h", pb.data, d);
        errors++;
      end
      if (last !== pb.last) begin
        $error("out_last_of_run: expected %0b actual %0b", pb.last, last);
        errors++;
      end
      if (eos !== pb.eos) begin
        $error("out_end_of_stream: expected %0b actual %0b", pb.eos, eos);
        errors++;
      end
    endfunction

    function int pending();
      return bytes_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  localparam int RANDOM_WORDS = 100;
  localparam int LONG_HOLD    = 120;   // cycles of solid out_stall
  localparam int TAIL_CYCLES  = 20;    // drain time after last byte due

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_command     = CMD_LOAD;
  logic [SYM_W-1:0]  in_symbol      = '0;
  logic [LEN_W-1:0]  in_code_length = '0;
  logic [CODE_W-1:0] in_code_bits   = '0;
  logic              out_stall      = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last_of_run;
  logic              out_end_of_stream;

  packer_scoreboard sb = new();

  bit hold_req  = 1'b0;   // raised by the stimulus to ask for the long hold
  bit hold_done = 1'b0;
  int burst_left = 0;
  logic [SYM_W-1:0] known_syms[$];   // recently loaded symbols, at most 24

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  huffman_code_bit_packer_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_symbol         (in_symbol),
    .in_code_length    (in_code_length),
    .in_code_bits      (in_code_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Present one word and hold it until accepted. Valid is left high so that
  // back-to-back words need no second assignment in the same step.
  task automatic offer_word(input logic cmd, input logic [SYM_W-1:0] sym,
                            input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_symbol      <= sym;
    in_code_length <= len;
    in_code_bits   <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(cmd, sym, len, bits);
  endtask

  // Burst pacing: count down the current burst, then drop valid for a gap.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Code length spread: mostly short codes, a few long, a few past the cap.
  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 60) return LEN_W'($urandom_range(1, 8));
    if (r < 85) return LEN_W'($urandom_range(9, 20));
    if (r < 95) return LEN_W'($urandom_range(21, 32));
    return LEN_W'($urandom_range(33, 63));
  endfunction

  task automatic send_load(input logic [SYM_W-1:0] sym);
    offer_word(CMD_LOAD, sym, pick_len(), $urandom());
    known_syms = {known_syms, sym};
    if (known_syms.size() > 24)
      void'(known_syms.pop_front());
  endtask

  // Encode; the length and bits fields carry junk since they are unused here.
  task automatic send_encode(input logic [SYM_W-1:0] sym);
    offer_word(CMD_ENCODE, sym, LEN_W'($urandom()), $urandom());
  endtask

  // Short directed opening: empty flush, unloaded symbols, length extremes,
  // saturation, a full byte flushed by the end symbol and a five-byte item.
  task automatic run_directed();
    send_encode(END_SYMBOL);                             // empty flush
    send_encode(8'd0);                                   // no code yet
    offer_word(CMD_LOAD, 8'd0,   6'd1,  32'hFFFF_FFFF);
    offer_word(CMD_LOAD, 8'd255, 6'd8,  32'h1234_56A5);  // junk above the code
    offer_word(CMD_LOAD, 8'd7,   6'd32, 32'hFFFF_FFFF);
    offer_word(CMD_LOAD, 8'd9,   6'd63, 32'h8000_0001);  // saturates
    offer_word(CMD_LOAD, END_SYMBOL, 6'd3, 32'h0000_0005);
    offer_word(CMD_LOAD, 8'd200, 6'd0,  32'hFFFF_FFFF);  // no code
    send_encode(8'd255);                                 // byte full, held
    send_encode(8'd0);                                   // pushes it out
    send_encode(8'd7);
    send_encode(8'd9);
    send_encode(8'd200);
    send_encode(END_SYMBOL);
    offer_word(CMD_LOAD, END_SYMBOL, 6'd32, 32'h0F0F_0F0F);
    send_encode(8'd255);
    send_encode(END_SYMBOL);                             // five bytes
    offer_word(CMD_LOAD, END_SYMBOL, 6'd0, 32'h0000_0000);
    send_encode(8'd255);
    send_encode(END_SYMBOL);                             // full byte flushed
    offer_word(CMD_LOAD, 8'd1, 6'd5, 32'h0000_0013);
    send_encode(8'd1);                                   // load then use
    send_encode(8'd1);
    send_encode(END_SYMBOL);
    known_syms = '{8'd0, 8'd255, 8'd7, 8'd9, 8'd1};
  endtask

  // One stream: a few loads, a run of encodes mostly of loaded symbols, and
  // usually the end symbol to close it.
  task automatic run_stream(inout int sent);
    int n_loads;
    int n_enc;
    int r;
    logic [SYM_W-1:0] sym;
    n_loads = $urandom_range(1, 4);
    for (int i = 0; i < n_loads; i++) begin
      sym = ($urandom_range(0, 9) == 0) ? END_SYMBOL : SYM_W'($urandom_range(0, 255));
      send_load(sym);
      pace();
      sent++;
    end
    n_enc = $urandom_range(3, 12);
    for (int i = 0; i < n_enc; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85)
        sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
      else
        sym = SYM_W'($urandom_range(0, 255));
      send_encode(sym);
      pace();
      sent++;
    end
    if ($urandom_range(0, 4) != 0) begin
      send_encode(END_SYMBOL);
      pace();
      sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: checks each accepted word, stalls in phases of its own and
  // once holds off for a long stretch so the pipeline backs up into in_stall.
  // --------------------------------------------------------------------------
  initial begin : rx_side
    int mode_left;
    int stall_pct;
    int hold_left;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall)
        sb.check_byte(out_byte, out_last_of_run, out_end_of_stream);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
        if (hold_left == 0)
          hold_done = 1'b1;
      end else if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_left = LONG_HOLD - 1;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
          mode_left = $urandom_range(5, 40);
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    int sent;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // random streams; the long receiver hold lands early in this part
    hold_req = 1'b1;
    while (sent < RANDOM_WORDS)
      run_stream(sent);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d words in, %0d bytes checked, %0d end-of-stream flushes",
             sb.words_in, sb.bytes_out, sb.flushes);
    $display("run: long output hold %0s, %0d mismatches",
             hold_done ? "done" : "not reached", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[huffman_code_bit_packer_unit] OK");
    else
      $display("[huffman_code_bit_packer_unit] ERROR");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("[huffman_code_bit_packer_unit] ERROR");
    $finish;
  end

endmodule

/* huffman_code_bit_packer_unit.f */
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_code_table.sv
hw/rtl/hcbp_packer.sv
hw/rtl/huffman_code_bit_packer_unit.sv
hw/rtl/hcbp_checker.sv
verif/tb_top.sv
